>>> design/gnh_pkg.sv
// gnh_pkg: shared types, constants and codes for the geographic next-hop table
// no dependencies
package gnh_pkg;

   localparam int unsigned TABLE_ENTRIES_DEF = 64;

   localparam int unsigned CMD_W   = 2;
   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned COORD_W = 16;
   localparam int unsigned STAMP_W = 32;
   localparam int unsigned SPACE_W = 32;
   localparam int unsigned TIME_W  = 48;
   localparam int unsigned RANK_W  = 8;
   localparam int unsigned STAT_W  = 3;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 48;

   // one table row, packed for the generic ram
   typedef struct packed {
      logic [ADDR_W-1:0]  addr;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [STAMP_W-1:0] stamp;
      logic [TIME_W-1:0]  btime;
      logic [SPACE_W-1:0] space;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

   typedef enum logic [CMD_W-1:0] {
      CMD_LOCATION = 2'd0,
      CMD_BEACON   = 2'd1,
      CMD_ROUTE    = 2'd2,
      CMD_UNUSED   = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_INSERTED = 3'd0,
      ST_UPDATED  = 3'd1,
      ST_KEPT     = 3'd2,
      ST_OWN      = 3'd3,
      ST_EVICTED  = 3'd4,
      ST_ROUTED   = 3'd5,
      ST_NOROUTE  = 3'd6,
      ST_SPARE    = 3'd7
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OWN_ADDR = 2'd0,
      CSR_BWAIT    = 2'd1,
      CSR_MARGIN   = 2'd2,
      CSR_NONE     = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [ADDR_W-1:0]  node_addr;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [STAMP_W-1:0] stamp;
      logic [SPACE_W-1:0] free_space;
      logic [TIME_W-1:0]  now_us;
      logic [SPACE_W-1:0] msg_size;
      logic [COORD_W-1:0] self_x;
      logic [COORD_W-1:0] self_y;
      logic [RANK_W-1:0]  rank;
   } req_type;

endpackage

>>> design/gnh_if.sv
// gnh_req_if / gnh_rsp_if: valid-ready channels of the next-hop table
// depends on gnh_pkg
interface gnh_req_if;
   logic                      valid;
   logic                      ready;
   logic [gnh_pkg::CMD_W-1:0]   cmd;
   logic [gnh_pkg::ADDR_W-1:0]  node_addr;
   logic [gnh_pkg::COORD_W-1:0] pos_x;
   logic [gnh_pkg::COORD_W-1:0] pos_y;
   logic [gnh_pkg::STAMP_W-1:0] stamp;
   logic [gnh_pkg::SPACE_W-1:0] free_space;
   logic [gnh_pkg::TIME_W-1:0]  now_us;
   logic [gnh_pkg::SPACE_W-1:0] msg_size;
   logic [gnh_pkg::COORD_W-1:0] self_x;
   logic [gnh_pkg::COORD_W-1:0] self_y;
   logic [gnh_pkg::RANK_W-1:0]  rank;
   modport source (output valid, cmd, node_addr, pos_x, pos_y, stamp, free_space,
                   now_us, msg_size, self_x, self_y, rank, input ready);
   modport sink   (input valid, cmd, node_addr, pos_x, pos_y, stamp, free_space,
                   now_us, msg_size, self_x, self_y, rank, output ready);
endinterface

interface gnh_rsp_if #(parameter int unsigned CNT_W = 7);
   logic                       valid;
   logic                       ready;
   logic [gnh_pkg::STAT_W-1:0] status;
   logic [gnh_pkg::ADDR_W-1:0] next_hop;
   logic [CNT_W-1:0]           entry_count;
   modport source (output valid, status, next_hop, entry_count, input ready);
   modport sink   (input valid, status, next_hop, entry_count, output ready);
endinterface

>>> design/gnh_ram.sv
// gnh_ram: generic single-port-write, one-read ram with registered read data
// no dependencies
module gnh_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

>>> design/geo_next_hop_table_top.sv
// geo_next_hop_table_top: sorted neighbour position table with greedy route lookup
// depends on gnh_pkg, gnh_if, gnh_ram
//
// One item is taken at a time; ready is low while it is worked on. Every pass
// over the table reads rows one at a time from a single ram with registered
// read, so costs are set by that read port and the table fill n (at most
// TABLE_ENTRIES). A location record or beacon to a known node costs a lookup
// plus one write. An insert adds a position search and a shift pass; on a full
// table an oldest-beacon search and a closing shift come first. A route query
// with rank zero is a lookup, then the margin square and self distance on one
// shared 16x16 multiplier, then a scan of the rows (two squares and a compare
// on the same multiplier). The longest item is an insert into a full table
// where the oldest beacon and the new slot both sit at row 0. The result waits
// in an output register and the block stays busy until it is transferred. The
// table needs no clearing pass: only rows below the fill count are read.
module geo_next_hop_table_top #(
   parameter int unsigned TABLE_ENTRIES = gnh_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   gnh_req_if.sink                          req,
   gnh_rsp_if.source                        rsp,
   input  logic                             csr_wr_en,
   input  logic [gnh_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gnh_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import gnh_pkg::*;

   localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
   localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_ENTRIES);

   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_LOOK   = 14'b00000000000010,  // read rows until match or end
      S_HIT    = 14'b00000000000100,  // act on found row
      S_OLD    = 14'b00000000001000,  // oldest beacon search
      S_DEL    = 14'b00000000010000,  // shift down over evicted row
      S_POS    = 14'b00000000100000,  // find insert position
      S_INS    = 14'b00000001000000,  // shift up to open a slot
      S_PUT    = 14'b00000010000000,  // write new row
      S_M2     = 14'b00000100000000,  // margin squared / self distance
      S_RRD    = 14'b00001000000000,  // route scan read
      S_RCHK   = 14'b00010000000000,  // latch the scanned row
      S_RDX    = 14'b00100000000000,  // freshness and space, dx squared
      S_RDY    = 14'b01000000000000,  // dy squared and compare
      S_OUT    = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [ADDR_W-1:0]  own_ff;
   logic [TIME_W-1:0]  bwait_ff;
   logic [COORD_W-1:0] margin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff    <= '0;
         bwait_ff  <= TIME_W'(10000000);
         margin_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_OWN_ADDR: own_ff    <= csr_wr_data[ADDR_W-1:0];
            CSR_BWAIT:    bwait_ff  <= csr_wr_data[TIME_W-1:0];
            CSR_MARGIN:   margin_ff <= csr_wr_data[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // table ram
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   entry_type        wr_data, rd_row;
   logic [ENTRY_W-1:0] rd_raw;

   gnh_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );
   assign rd_row = entry_type'(rd_raw);

   // item and working registers
   req_type          item_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;       // row being issued
   logic             pend_ff, pend_in;     // a read is in flight
   logic [CNT_W-1:0] rptr_ff, rptr_in;     // row of data now on rd_row
   logic [CNT_W-1:0] hit_ff, hit_in;       // found / oldest / target row
   logic [TIME_W-1:0] old_ff, old_in;
   logic [STAT_W-1:0] st_ff, st_in;
   logic [ADDR_W-1:0] hop_ff, hop_in;
   entry_type        row_ff, row_in;       // held row for scan / shift
   logic [COORD_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [2*COORD_W+1:0] self_d_ff, self_d_in, m2_ff, m2_in, acc_ff, acc_in;
   logic             evict_ff, evict_in;
   logic             phase_ff, phase_in;

   // shared multiplier, one registered product
   logic [COORD_W-1:0]     mul_a, mul_b;
   logic [2*COORD_W-1:0]   prod_ff;
   always_ff @(posedge clock) prod_ff <= mul_a * mul_b;

   function automatic logic [COORD_W-1:0] absdiff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   logic fire;
   assign fire = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);

   logic [TIME_W:0] deadline;
   assign deadline = {1'b0, row_ff.btime} + {1'b0, bwait_ff};

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      pend_in  = 1'b0;
      rptr_in  = ptr_ff;
      hit_in   = hit_ff;
      old_in   = old_ff;
      st_in    = st_ff;
      hop_in   = hop_ff;
      row_in   = row_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      self_d_in = self_d_ff;
      m2_in    = m2_ff;
      acc_in   = acc_ff;
      evict_in = evict_ff;
      phase_in = phase_ff;
      wr_en    = 1'b0;
      wr_addr  = hit_ff[IDX_W-1:0];
      wr_data  = row_ff;
      rd_addr  = ptr_ff[IDX_W-1:0];
      mul_a    = dx_ff;
      mul_b    = dx_ff;

      case (state_ff)
         S_IDLE: begin
            if (fire) begin
               ptr_in   = '0;
               hit_in   = FULL;
               evict_in = 1'b0;
               hop_in   = '0;
               st_in    = ST_NOROUTE;
               case (cmd_type'(req.cmd))
                  CMD_LOCATION:
                     if (req.node_addr == own_ff) begin
                        st_in = ST_OWN;
                        state_in = S_OUT;
                     end else begin
                        state_in = S_LOOK;
                     end
                  CMD_BEACON: state_in = S_LOOK;
                  CMD_ROUTE:
                     state_in = (req.rank != '0) ? S_OUT : S_LOOK;
                  default: state_in = S_OUT;
               endcase
            end
         end

         // read each row, compare the one arriving
         S_LOOK: begin
            if (pend_ff && rd_row.addr == item_ff.node_addr) begin
               hit_in   = rptr_ff;
               row_in   = rd_row;
               state_in = S_HIT;
            end else if (ptr_ff < count_ff) begin
               rd_addr = ptr_ff[IDX_W-1:0];
               pend_in = 1'b1;
               rptr_in = ptr_ff;
               ptr_in  = ptr_ff + 1'b1;
            end else if (!pend_ff) begin
               if (cmd_type'(item_ff.cmd) == CMD_ROUTE) begin
                  state_in = S_OUT;
               end else if (count_ff == FULL) begin
                  ptr_in   = '0;
                  hit_in   = '0;
                  state_in = S_OLD;
               end else begin
                  ptr_in   = '0;
                  state_in = S_POS;
               end
            end
         end

         S_HIT: begin
            if (cmd_type'(item_ff.cmd) == CMD_ROUTE) begin
               dx_in    = absdiff(item_ff.self_x, row_ff.x);
               dy_in    = absdiff(item_ff.self_y, row_ff.y);
               row_in.x = row_ff.x;
               phase_in = 1'b0;
               state_in = S_M2;
            end else begin
               wr_en   = 1'b1;
               wr_addr = hit_ff[IDX_W-1:0];
               wr_data = row_ff;
               if (row_ff.stamp < item_ff.stamp) begin
                  wr_data.x     = item_ff.pos_x;
                  wr_data.y     = item_ff.pos_y;
                  wr_data.stamp = item_ff.stamp;
                  st_in = ST_UPDATED;
               end else begin
                  st_in = ST_KEPT;
               end
               if (cmd_type'(item_ff.cmd) == CMD_BEACON) begin
                  wr_data.btime = item_ff.now_us;
                  wr_data.space = item_ff.free_space;
               end
               state_in = S_OUT;
            end
         end

         // smallest beacon time, lowest row on ties
         S_OLD: begin
            if (pend_ff && (rptr_ff == '0 || rd_row.btime < old_ff)) begin
               old_in = rd_row.btime;
               hit_in = rptr_ff;
            end
            if (ptr_ff < count_ff) begin
               rd_addr = ptr_ff[IDX_W-1:0];
               pend_in = 1'b1;
               rptr_in = ptr_ff;
               ptr_in  = ptr_ff + 1'b1;
            end else if (!pend_ff) begin
               ptr_in   = hit_in + 1'b1;
               phase_in = 1'b0;
               state_in = S_DEL;
            end
         end

         // move rows above the evicted one down by one
         S_DEL: begin
            if (ptr_ff >= count_ff) begin
               count_in = count_ff - 1'b1;
               evict_in = 1'b1;
               ptr_in   = '0;
               state_in = S_POS;
            end else if (!phase_ff) begin
               rd_addr  = ptr_ff[IDX_W-1:0];
               phase_in = 1'b1;
            end else if (!pend_ff) begin
               pend_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = IDX_W'(ptr_ff - 1'b1);
               wr_data  = rd_row;
               ptr_in   = ptr_ff + 1'b1;
               phase_in = 1'b0;
            end
         end

         // first row whose address is not below the new one
         S_POS: begin
            if (pend_ff && !(rd_row.addr < item_ff.node_addr)) begin
               hit_in   = rptr_ff;
               ptr_in   = count_ff;
               phase_in = 1'b0;
               state_in = S_INS;
            end else if (ptr_ff < count_ff) begin
               rd_addr = ptr_ff[IDX_W-1:0];
               pend_in = 1'b1;
               rptr_in = ptr_ff;
               ptr_in  = ptr_ff + 1'b1;
            end else if (!pend_ff) begin
               hit_in   = count_ff;
               ptr_in   = count_ff;
               phase_in = 1'b0;
               state_in = S_INS;
            end
         end

         // move rows from the slot upward by one, top first
         S_INS: begin
            if (ptr_ff <= hit_ff) begin
               state_in = S_PUT;
            end else if (!phase_ff) begin
               rd_addr  = IDX_W'(ptr_ff - 1'b1);
               phase_in = 1'b1;
            end else if (!pend_ff) begin
               rd_addr = IDX_W'(ptr_ff - 1'b1);
               pend_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = ptr_ff[IDX_W-1:0];
               wr_data  = rd_row;
               ptr_in   = ptr_ff - 1'b1;
               phase_in = 1'b0;
            end
         end

         S_PUT: begin
            wr_en         = 1'b1;
            wr_addr       = hit_ff[IDX_W-1:0];
            wr_data.addr  = item_ff.node_addr;
            wr_data.x     = item_ff.pos_x;
            wr_data.y     = item_ff.pos_y;
            wr_data.stamp = item_ff.stamp;
            wr_data.btime = '0;
            wr_data.space = '0;
            if (cmd_type'(item_ff.cmd) == CMD_BEACON) begin
               wr_data.btime = item_ff.now_us;
               wr_data.space = item_ff.free_space;
            end
            count_in = count_ff + 1'b1;
            st_in    = evict_ff ? ST_EVICTED : ST_INSERTED;
            state_in = S_OUT;
         end

         // margin squared, then self dx^2 and dy^2 through the multiplier
         S_M2: begin
            if (!phase_ff) begin
               mul_a    = margin_ff;
               mul_b    = margin_ff;
               phase_in = 1'b1;
               acc_in   = '0;
               hit_in   = '0;
            end else if (hit_ff == '0) begin
               m2_in  = {2'b00, prod_ff};
               mul_a  = dx_ff;
               mul_b  = dx_ff;
               hit_in = CNT_W'(1);
            end else if (hit_ff == CNT_W'(1)) begin
               acc_in = {2'b00, prod_ff};
               mul_a  = dy_ff;
               mul_b  = dy_ff;
               hit_in = CNT_W'(2);
            end else begin
               self_d_in = acc_ff + {2'b00, prod_ff};
               dx_in     = row_ff.x;
               dy_in     = row_ff.y;
               ptr_in    = '0;
               state_in  = S_RRD;
            end
         end

         S_RRD: begin
            if (ptr_ff >= count_ff) begin
               state_in = S_OUT;
            end else begin
               rd_addr  = ptr_ff[IDX_W-1:0];
               rptr_in  = ptr_ff;
               state_in = S_RCHK;
            end
         end

         S_RCHK: begin
            row_in   = rd_row;
            ptr_in   = rptr_ff + 1'b1;
            state_in = S_RDX;
            phase_in = 1'b0;
         end

         S_RDX: begin
            // dx_ff / dy_ff hold the destination position here
            if ({1'b0, item_ff.now_us} > deadline ||
                row_ff.space < item_ff.msg_size) begin
               state_in = S_RRD;
            end else if (row_ff.addr == item_ff.node_addr) begin
               hop_in   = item_ff.node_addr;
               st_in    = ST_ROUTED;
               state_in = S_OUT;
            end else begin
               mul_a    = absdiff(row_ff.x, dx_ff);
               mul_b    = absdiff(row_ff.x, dx_ff);
               state_in = S_RDY;
            end
         end

         S_RDY: begin
            if (!phase_ff) begin
               acc_in   = {2'b00, prod_ff} + m2_ff;
               mul_a    = absdiff(row_ff.y, dy_ff);
               mul_b    = absdiff(row_ff.y, dy_ff);
               phase_in = 1'b1;
            end else if (acc_ff + {2'b00, prod_ff} < self_d_ff) begin
               if (row_ff.addr != own_ff) begin
                  hop_in = row_ff.addr;
                  st_in  = ST_ROUTED;
               end
               state_in = S_OUT;
            end else begin
               state_in = S_RRD;
            end
         end

         S_OUT: begin
            if (rsp.ready) state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) item_ff <= req_type'({req.cmd, req.node_addr, req.pos_x, req.pos_y,
                                     req.stamp, req.free_space, req.now_us,
                                     req.msg_size, req.self_x, req.self_y,
                                     req.rank});
      ptr_ff    <= ptr_in;
      rptr_ff   <= rptr_in;
      hit_ff    <= hit_in;
      old_ff    <= old_in;
      st_ff     <= st_in;
      hop_ff    <= hop_in;
      row_ff    <= row_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      self_d_ff <= self_d_in;
      m2_ff     <= m2_in;
      acc_ff    <= acc_in;
      evict_ff  <= evict_in;
      phase_ff  <= phase_in;
   end

   // result register, held until transferred
   assign rsp.valid       = (state_ff == S_OUT);
   assign rsp.status      = st_ff;
   assign rsp.next_hop    = hop_ff;
   assign rsp.entry_count = count_ff;
endmodule

>>> design/gnh_checker.sv
// gnh_checker: port-level assertions for the next-hop table, bound to the top
// depends on gnh_pkg, gnh_if
module gnh_checker #(
   parameter int unsigned TABLE_ENTRIES = gnh_pkg::TABLE_ENTRIES_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [gnh_pkg::STAT_W-1:0] rsp_status,
   input logic [gnh_pkg::ADDR_W-1:0] rsp_next_hop,
   input logic [$clog2(TABLE_ENTRIES+1)-1:0] rsp_entry_count
);
   import gnh_pkg::*;

   // never takes a request while a result is waiting
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");

   // no hop unless routed
   a_hop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_ROUTED |-> rsp_next_hop == '0)
      else $error("hop without route");

   // fill never exceeds the table
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= ($clog2(TABLE_ENTRIES+1))'(TABLE_ENTRIES))
      else $error("fill count overflow");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped");
endmodule

bind geo_next_hop_table_top gnh_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_chk (
   .clock(clock), .reset(reset),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.status), .rsp_next_hop(rsp.next_hop),
   .rsp_entry_count(rsp.entry_count)
);
